@@ rtl/dqv_pkg.sv @@
package dqv_pkg;

  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [9:0] OCTET_MAX = 10'd255;
  localparam logic [2:0] GRP_MAX   = 3'd3;
  localparam logic [2:0] CNT_SAT   = 3'd4;
  localparam logic [2:0] DOTS_REQ  = 3'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_RANGE    = 3'd1;
  localparam logic [2:0] ERR_LENGTH   = 3'd2;
  localparam logic [2:0] ERR_ZERO_TWO = 3'd3;
  localparam logic [2:0] ERR_ZERO_THR = 3'd4;
  localparam logic [2:0] ERR_NONDIGIT = 3'd5;

  localparam logic [1:0] LZ_NONE  = 2'd0;
  localparam logic [1:0] LZ_TWO   = 2'd1;
  localparam logic [1:0] LZ_THREE = 2'd2;

  localparam int TQ_DEPTH = 4;
  localparam int TQ_AW    = $clog2(TQ_DEPTH);
  localparam int RQ_DEPTH = 2;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  typedef struct packed {
    logic       is_dot;
    logic       is_digit;
    logic       is_zero;
    logic [3:0] digit;
    logic       last;
  } tok_t;

  typedef struct packed {
    logic        is_valid;
    logic [2:0]  error_code;
    logic [31:0] address_value;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/dqv_front.sv @@
module dqv_front import dqv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  input  q_stat_t    q_stat,
  output logic       tok_wr,
  output tok_t       tok
);

  logic tok_valid_r;
  logic tok_valid_nxt;
  tok_t tok_r;
  tok_t tok_nxt;
  logic take;

  assign tok_wr  = tok_valid_r && !q_stat.full;
  assign in_full = tok_valid_r && q_stat.full;
  assign take    = in_push && !in_full;
  assign tok     = tok_r;

  always_comb begin
    tok_nxt.is_dot   = (in_char_code == CH_DOT);
    tok_nxt.is_digit = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);
    tok_nxt.is_zero  = (in_char_code == CH_ZERO);
    tok_nxt.digit    = in_char_code[3:0];
    tok_nxt.last     = in_last_char;
    tok_valid_nxt    = take || (tok_valid_r && !tok_wr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

@@ rtl/dqv_tok_queue.sv @@
module dqv_tok_queue import dqv_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  tok_t    wr_tok,
  input  logic    rd_en,
  output tok_t    rd_tok,
  output q_stat_t q_stat
);

  tok_t              mem [TQ_DEPTH];
  logic [TQ_AW-1:0]  wr_ptr_r;
  logic [TQ_AW-1:0]  rd_ptr_r;
  logic [TQ_AW:0]    cnt_r;
  logic [TQ_AW:0]    cnt_nxt;
  logic              do_wr;
  logic              do_rd;

  assign q_stat.full  = (cnt_r == (TQ_AW+1)'(TQ_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_wr        = wr_en && !q_stat.full;
  assign do_rd        = rd_en && !q_stat.empty;
  assign rd_tok       = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_tok;
    end
  end

endmodule

@@ rtl/dqv_back.sv @@
module dqv_back import dqv_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_stat_t q_stat,
  input  tok_t    tok,
  output logic    tok_rd,
  output logic    out_empty,
  input  logic    out_pop,
  output res_t    res
);

  logic [2:0]  gl_r,  gl_nxt;
  logic [9:0]  gv_r,  gv_nxt;
  logic        gsz_r, gsz_nxt;
  logic [2:0]  dc_r,  dc_nxt;
  logic        le_r,  le_nxt;
  logic [1:0]  lz_r,  lz_nxt;
  logic        nd_r,  nd_nxt;
  logic        re_r,  re_nxt;
  logic [31:0] pa_r,  pa_nxt;

  logic [2:0]  gl_a;
  logic [9:0]  gv_a;
  logic        gsz_a;
  logic        le_a;
  logic        nd_a;
  logic [2:0]  dc_a;
  logic        le_c;
  logic [1:0]  lz_c;
  logic        re_c;
  logic [31:0] pa_c;
  logic        le_f;
  logic [2:0]  code;
  res_t        res_new;

  res_t              rq [RQ_DEPTH];
  logic [RQ_AW-1:0]  rq_wr_r;
  logic [RQ_AW-1:0]  rq_rd_r;
  logic [RQ_AW:0]    rq_cnt_r;
  logic [RQ_AW:0]    rq_cnt_nxt;
  logic              rq_full;
  logic              rq_pop;
  logic              rq_push;

  assign out_empty = (rq_cnt_r == '0);
  assign rq_full   = (rq_cnt_r == (RQ_AW+1)'(RQ_DEPTH));
  assign rq_pop    = out_pop && !out_empty;
  assign tok_rd    = !q_stat.empty && (!rq_full || rq_pop);
  assign rq_push   = tok_rd && tok.last;
  assign res       = rq[rq_rd_r];

  always_comb begin
    gl_a  = gl_r;
    gv_a  = gv_r;
    gsz_a = gsz_r;
    le_a  = le_r;
    nd_a  = nd_r;
    dc_a  = dc_r;
    if (tok.is_dot) begin
      if (dc_r < CNT_SAT) begin
        dc_a = dc_r + 1'b1;
      end
    end else begin
      if (gl_r >= GRP_MAX) begin
        le_a = 1'b1;
      end
      if (gl_r == '0) begin
        gsz_a = tok.is_zero;
      end
      if (tok.is_digit) begin
        if (gl_r < GRP_MAX) begin
          gv_a = (gv_r << 3) + (gv_r << 1) + {6'd0, tok.digit};
        end
      end else begin
        nd_a = 1'b1;
      end
      if (gl_r < CNT_SAT) begin
        gl_a = gl_r + 1'b1;
      end
    end

    le_c = le_a || (gl_a == '0) || (gl_a > GRP_MAX);
    lz_c = lz_r;
    if (lz_r == LZ_NONE && gsz_a) begin
      if (gl_a == 3'd2) begin
        lz_c = LZ_TWO;
      end else if (gl_a == 3'd3) begin
        lz_c = LZ_THREE;
      end
    end
    re_c = re_r || (gv_a > OCTET_MAX);
    pa_c = {pa_r[23:0], gv_a[7:0]};
    // A dot as the final character leaves an empty last group.
    le_f = le_c || (dc_a != DOTS_REQ) || tok.is_dot;

    if (le_f) begin
      code = ERR_LENGTH;
    end else if (lz_c == LZ_TWO) begin
      code = ERR_ZERO_TWO;
    end else if (lz_c != LZ_NONE) begin
      code = ERR_ZERO_THR;
    end else if (nd_a) begin
      code = ERR_NONDIGIT;
    end else if (re_c) begin
      code = ERR_RANGE;
    end else begin
      code = ERR_NONE;
    end
    res_new.is_valid      = (code == ERR_NONE);
    res_new.error_code    = code;
    res_new.address_value = (code == ERR_NONE) ? pa_c : 32'd0;

    gl_nxt  = gl_r;
    gv_nxt  = gv_r;
    gsz_nxt = gsz_r;
    dc_nxt  = dc_r;
    le_nxt  = le_r;
    lz_nxt  = lz_r;
    nd_nxt  = nd_r;
    re_nxt  = re_r;
    pa_nxt  = pa_r;
    if (tok_rd) begin
      if (tok.last) begin
        gl_nxt  = '0;
        gv_nxt  = '0;
        gsz_nxt = 1'b0;
        dc_nxt  = '0;
        le_nxt  = 1'b0;
        lz_nxt  = LZ_NONE;
        nd_nxt  = 1'b0;
        re_nxt  = 1'b0;
        pa_nxt  = '0;
      end else if (tok.is_dot) begin
        gl_nxt  = '0;
        gv_nxt  = '0;
        gsz_nxt = 1'b0;
        dc_nxt  = dc_a;
        le_nxt  = le_c;
        lz_nxt  = lz_c;
        nd_nxt  = nd_a;
        re_nxt  = re_c;
        pa_nxt  = pa_c;
      end else begin
        gl_nxt  = gl_a;
        gv_nxt  = gv_a;
        gsz_nxt = gsz_a;
        le_nxt  = le_a;
        nd_nxt  = nd_a;
      end
    end

    rq_cnt_nxt = rq_cnt_r;
    if (rq_push && !rq_pop) begin
      rq_cnt_nxt = rq_cnt_r + 1'b1;
    end else if (rq_pop && !rq_push) begin
      rq_cnt_nxt = rq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gl_r     <= '0;
      gv_r     <= '0;
      gsz_r    <= 1'b0;
      dc_r     <= '0;
      le_r     <= 1'b0;
      lz_r     <= LZ_NONE;
      nd_r     <= 1'b0;
      re_r     <= 1'b0;
      pa_r     <= '0;
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      gl_r     <= gl_nxt;
      gv_r     <= gv_nxt;
      gsz_r    <= gsz_nxt;
      dc_r     <= dc_nxt;
      le_r     <= le_nxt;
      lz_r     <= lz_nxt;
      nd_r     <= nd_nxt;
      re_r     <= re_nxt;
      pa_r     <= pa_nxt;
      rq_cnt_r <= rq_cnt_nxt;
      if (rq_push) begin
        rq_wr_r <= rq_wr_r + 1'b1;
      end
      if (rq_pop) begin
        rq_rd_r <= rq_rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq[rq_wr_r] <= res_new;
    end
  end

endmodule

@@ rtl/ipv4_dotted_quad_validator.sv @@
// Output: a result reaches the output ports once the last character of a string has passed
// the front-end token register, the token queue and the back end's result queue.
// Throughput: one character per cycle while in_full is low; in_full stalls the input when the queues fill up.
// Reset is synchronous and active low; it clears all control state and the parser state,
// while queue storage is left as is.
module ipv4_dotted_quad_validator import dqv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_is_valid,
  output logic [2:0]  out_error_code,
  output logic [31:0] out_address_value
);

  q_stat_t q_stat;
  logic    tok_wr;
  tok_t    wr_tok;
  logic    tok_rd;
  tok_t    rd_tok;
  res_t    res;

  dqv_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .q_stat       (q_stat),
    .tok_wr       (tok_wr),
    .tok          (wr_tok)
  );

  dqv_tok_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (tok_wr),
    .wr_tok (wr_tok),
    .rd_en  (tok_rd),
    .rd_tok (rd_tok),
    .q_stat (q_stat)
  );

  dqv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .tok       (rd_tok),
    .tok_rd    (tok_rd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res       (res)
  );

  assign out_is_valid      = res.is_valid;
  assign out_error_code    = res.error_code;
  assign out_address_value = res.address_value;

`ifndef NO_ASSERTIONS
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_valid_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_is_valid == (out_error_code == ERR_NONE)))
    else $error("verdict and error code disagree");

  a_invalid_addr: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_is_valid |-> out_address_value == 32'd0)
    else $error("address given for an invalid string");

  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("token queue both full and empty");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> q_stat.full)
    else $error("input stalled while token queue has room");
`endif

endmodule

@@ test/ipv4_dotted_quad_validator_tb.sv @@
module ipv4_dotted_quad_validator_tb;
  import dqv_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_CHARS = 1750;
  localparam int IDLE_PCT     = 7;
  localparam int TAIL_CYCLES  = 20;

  typedef struct {
    logic [7:0]  ch;
    logic        last;
    logic        typed;
    logic        valid;
    logic [2:0]  code;
    logic [31:0] addr;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_char_code = 8'h00;
  logic        in_last_char = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_is_valid;
  logic [2:0]  out_error_code;
  logic [31:0] out_address_value;

  ipv4_dotted_quad_validator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_char_code(in_char_code),
    .in_last_char(in_last_char),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_is_valid(out_is_valid),
    .out_error_code(out_error_code),
    .out_address_value(out_address_value)
  );

  always #10 clk = ~clk;

  // Parser state mirrored from the block.
  logic [2:0]  grp_len;
  logic [9:0]  grp_val;
  logic        grp_zero;
  logic [2:0]  dots;
  logic        len_err;
  logic [1:0]  lz_kind;
  logic        nd_err;
  logic        rng_err;
  logic [31:0] addr_acc;

  res_t     verdict_q[$];
  int       errors = 0;
  int       cycles = 0;
  bit       calm = 1'b0;
  dir_row_t dir_tab[27];

  function automatic void clear_parser();
    grp_len  = '0;
    grp_val  = '0;
    grp_zero = 1'b0;
    dots     = '0;
    len_err  = 1'b0;
    lz_kind  = LZ_NONE;
    nd_err   = 1'b0;
    rng_err  = 1'b0;
    addr_acc = '0;
  endfunction

  function automatic void close_octet();
    if (grp_len == 3'd0 || grp_len > GRP_MAX) len_err = 1'b1;
    if (lz_kind == LZ_NONE && grp_zero) begin
      if (grp_len == 3'd2) lz_kind = LZ_TWO;
      else if (grp_len == 3'd3) lz_kind = LZ_THREE;
    end
    if (grp_val > OCTET_MAX) rng_err = 1'b1;
    addr_acc = {addr_acc[23:0], grp_val[7:0]};
    grp_len  = '0;
    grp_val  = '0;
    grp_zero = 1'b0;
  endfunction

  // Returns 1 when the character ends a string, with the verdict in res.
  function automatic bit parse_char(input logic [7:0] ch, input logic last, output res_t res);
    logic [2:0] code;
    res = '0;
    if (ch == CH_DOT) begin
      close_octet();
      if (dots < CNT_SAT) dots = dots + 3'd1;
    end else begin
      if (grp_len >= GRP_MAX) len_err = 1'b1;
      if (grp_len == 3'd0) grp_zero = (ch == CH_ZERO);
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        if (grp_len < GRP_MAX) grp_val = 10'(grp_val * 10 + 10'(ch - CH_ZERO));
      end else begin
        nd_err = 1'b1;
      end
      if (grp_len < CNT_SAT) grp_len = grp_len + 3'd1;
    end
    if (!last) return 1'b0;
    close_octet();
    if (dots != DOTS_REQ) len_err = 1'b1;
    if (len_err) code = ERR_LENGTH;
    else if (lz_kind == LZ_TWO) code = ERR_ZERO_TWO;
    else if (lz_kind != LZ_NONE) code = ERR_ZERO_THR;
    else if (nd_err) code = ERR_NONDIGIT;
    else if (rng_err) code = ERR_RANGE;
    else code = ERR_NONE;
    res.is_valid      = (code == ERR_NONE);
    res.error_code    = code;
    res.address_value = (code == ERR_NONE) ? addr_acc : 32'd0;
    clear_parser();
    return 1'b1;
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic last, input bit typed,
                           input res_t typed_res);
    res_t res;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_char_code <= ch;
    in_last_char <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (parse_char(ch, last, res)) verdict_q.push_back(typed ? typed_res : res);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic push_digit(ref logic [7:0] text[$], input int d);
    text.push_back(CH_ZERO + 8'(d));
  endtask

  task automatic build_string(ref logic [7:0] text[$]);
    int ngroups;
    int mode;
    int n;
    int v;
    ngroups = ($urandom_range(0, 99) < 85) ? 4 : $urandom_range(1, 6);
    for (int g = 0; g < ngroups; g++) begin
      if (g != 0) text.push_back(CH_DOT);
      mode = $urandom_range(0, 99);
      if (mode < 60) begin
        v = $urandom_range(0, 255);
        if (v >= 100) push_digit(text, v / 100);
        if (v >= 10) push_digit(text, (v / 10) % 10);
        push_digit(text, v % 10);
      end else if (mode < 85) begin
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++)
          push_digit(text, (k == 0 && $urandom_range(0, 99) < 40) ? 0 : $urandom_range(0, 9));
      end else if (mode < 92) begin
        n = $urandom_range(4, 6);
        for (int k = 0; k < n; k++) push_digit(text, $urandom_range(0, 9));
      end else if (mode < 96) begin
        // An empty group.
      end else begin
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) text.push_back(8'($urandom_range(0, 255)));
      end
    end
    if (text.size() == 0) text.push_back(CH_DOT);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("ipv4_dotted_quad_validator test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected transaction, actual valid %0b code %0d addr %08h", $time,
                 out_is_valid, out_error_code, out_address_value);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        if (out_is_valid !== want.is_valid) begin
          $display("%0t: is_valid expected %0b actual %0b", $time, want.is_valid,
                   out_is_valid);
          errors++;
        end
        if (out_error_code !== want.error_code) begin
          $display("%0t: error_code expected %0d actual %0d", $time, want.error_code,
                   out_error_code);
          errors++;
        end
        if (out_address_value !== want.address_value) begin
          $display("%0t: address_value expected %08h actual %08h", $time,
                   want.address_value, out_address_value);
          errors++;
        end
      end
    end
    out_pop <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
  end

  initial begin
    res_t        typed_res;
    logic [7:0]  text[$];
    int          sent;
    int          nstr;
    dir_tab = '{
      '{8'h00,  1'b1, 1'b1, 1'b0, ERR_LENGTH,   32'd0},
      '{8'hFF,  1'b1, 1'b1, 1'b0, ERR_LENGTH,   32'd0},
      '{CH_DOT, 1'b1, 1'b1, 1'b0, ERR_LENGTH,   32'd0},
      '{"0",    1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{CH_DOT, 1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{"0",    1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{CH_DOT, 1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{"0",    1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{CH_DOT, 1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{"0",    1'b1, 1'b1, 1'b1, ERR_NONE,     32'd0},
      '{"9",    1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{CH_DOT, 1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{"0",    1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{CH_DOT, 1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{"0",    1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{CH_DOT, 1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{"0",    1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{"9",    1'b1, 1'b1, 1'b0, ERR_ZERO_TWO, 32'd0},
      '{"1",    1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{CH_DOT, 1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{"0",    1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{CH_DOT, 1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{"0",    1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{CH_DOT, 1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{"9",    1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{"9",    1'b0, 1'b0, 1'b0, ERR_NONE,     32'd0},
      '{"9",    1'b1, 1'b1, 1'b0, ERR_RANGE,    32'd0}
    };
    clear_parser();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      typed_res.is_valid      = dir_tab[i].valid;
      typed_res.error_code    = dir_tab[i].code;
      typed_res.address_value = dir_tab[i].addr;
      send_char(dir_tab[i].ch, dir_tab[i].last, dir_tab[i].typed, typed_res);
    end

    // The sender holds off now and then until every verdict is back.
    drain();
    sent = 0;
    nstr = 0;
    typed_res = '0;
    while (sent < RANDOM_CHARS) begin
      text.delete();
      build_string(text);
      calm = (nstr >= 40 && nstr < 70);
      foreach (text[i]) send_char(text[i], i == text.size() - 1, 1'b0, typed_res);
      sent += text.size();
      nstr++;
      if (nstr % 50 == 0) drain();
    end
    calm = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("ipv4_dotted_quad_validator test passed");
    end else begin
      $display("ipv4_dotted_quad_validator test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/dqv_pkg.sv
rtl/dqv_front.sv
rtl/dqv_tok_queue.sv
rtl/dqv_back.sv
rtl/ipv4_dotted_quad_validator.sv
test/ipv4_dotted_quad_validator_tb.sv
